FILE: src/vau_pkg.sv
package vau_pkg;

   localparam int FRAC_BITS = 16;
   localparam int WORD_BITS = 32;
   localparam int DW        = 32;
   localparam int EW        = (WORD_BITS < DW) ? WORD_BITS : DW;
   localparam int OPW       = EW + 1;
   localparam int PW        = 2 * OPW;
   localparam int SW        = PW + 2;
   localparam int PPW       = 2 * EW;
   localparam int RADW      = 2 * EW + 2;
   localparam int RTW       = EW + 1;
   localparam int RW        = RTW + 3;
   localparam int NUMW      = EW + FRAC_BITS;
   localparam int SATW      = (2 * EW + 4 > EW + FRAC_BITS + 2) ? 2 * EW + 4
                                                                : EW + FRAC_BITS + 2;

   localparam logic signed [SATW-1:0] SAT_MAX = {{(SATW-EW+1){1'b0}}, {(EW-1){1'b1}}};
   localparam logic signed [SATW-1:0] SAT_MIN = {{(SATW-EW+1){1'b1}}, {(EW-1){1'b0}}};

   typedef enum logic [3:0] {
      MODE_ADD, MODE_SUB, MODE_NEG, MODE_SCALE, MODE_DIV, MODE_DOT, MODE_CROSS,
      MODE_NORM, MODE_LEN, MODE_LENSQ, MODE_DIST, MODE_DISTSQ, MODE_PROJECT, MODE_EQUAL
   } vau_mode_type;

   localparam logic [1:0] FAULT_NONE = 2'd0;
   localparam logic [1:0] FAULT_SAT  = 2'd1;
   localparam logic [1:0] FAULT_DIV0 = 2'd2;

   typedef struct packed {
      logic [3:0]           mode;
      logic signed [DW-1:0] ax;
      logic signed [DW-1:0] ay;
      logic signed [DW-1:0] az;
      logic signed [DW-1:0] bx;
      logic signed [DW-1:0] by;
      logic signed [DW-1:0] bz;
      logic signed [DW-1:0] factor;
   } vau_req_type;

   typedef struct packed {
      logic signed [DW-1:0] res_x;
      logic signed [DW-1:0] res_y;
      logic signed [DW-1:0] res_z;
      logic signed [DW-1:0] res_scalar;
      logic                 is_equal;
      logic [1:0]           fault;
   } vau_rsp_type;

   // item state carried down the root and divide pipelines
   typedef struct packed {
      logic [3:0]           mode;
      vau_rsp_type          rsp;
      logic [2:0][EW-1:0]   am;
      logic [2:0]           asn;
      logic [EW-1:0]        fm;
      logic                 fsn;
      logic                 fzero;
   } vau_ctx_type;

   typedef struct packed {
      logic signed [DW-1:0] val;
      logic                 ovf;
   } vau_sat_type;

   function automatic logic signed [EW-1:0] sext_ew(input logic [DW-1:0] raw);
      return $signed(raw[EW-1:0]);
   endfunction

   function automatic vau_sat_type sat_ew(input logic signed [SATW-1:0] v);
      logic signed [SATW-1:0] c;
      vau_sat_type r;
      if (v > SAT_MAX) begin
         c = SAT_MAX;
      end else if (v < SAT_MIN) begin
         c = SAT_MIN;
      end else begin
         c = v;
      end
      r.ovf = (v > SAT_MAX) || (v < SAT_MIN);
      r.val = DW'($signed(c[EW-1:0]));
      return r;
   endfunction

endpackage

FILE: src/vau_prod.sv
module vau_prod (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_vld,
   input  vau_pkg::vau_req_type      in_req,
   output logic                      out_vld,
   output logic [vau_pkg::RADW-1:0]  out_rad,
   output vau_pkg::vau_ctx_type      out_ctx
);
   import vau_pkg::*;

   logic        [6:0]      vld_ff;
   logic        [6:0]      vld_in;

   vau_req_type            req1_ff;

   vau_ctx_type            ctx2_ff, ctx2_in;
   logic signed [OPW-1:0]  opx2_ff [6];
   logic signed [OPW-1:0]  opx2_in [6];
   logic signed [OPW-1:0]  opy2_ff [6];
   logic signed [OPW-1:0]  opy2_in [6];
   logic signed [EW-1:0]   b2_ff [3];

   vau_ctx_type            ctx3_ff;
   logic signed [PW-1:0]   p3_ff [6];
   logic signed [PW-1:0]   p3_in [6];
   logic signed [EW-1:0]   b3_ff [3];

   vau_ctx_type            ctx4_ff;
   logic signed [SW-1:0]   c4_ff [3];
   logic signed [SW-1:0]   c4_in [3];
   logic signed [EW-1:0]   b4_ff [3];

   vau_ctx_type            ctx5_ff, ctx5_in;
   logic [RADW-1:0]        rad5_ff;
   logic signed [EW-1:0]   ps5_ff, ps5_in;
   logic signed [EW-1:0]   b5_ff [3];

   vau_ctx_type            ctx6_ff;
   logic [RADW-1:0]        rad6_ff;
   logic signed [PPW-1:0]  pp6_ff [3];
   logic signed [PPW-1:0]  pp6_in [3];

   vau_ctx_type            ctx7_ff, ctx7_in;
   logic [RADW-1:0]        rad7_ff;

   // stage 2: operand select, add/sub/neg/equal
   logic signed [EW-1:0]   a [3];
   logic signed [EW-1:0]   b [3];
   logic signed [EW-1:0]   f;
   logic signed [OPW-1:0]  d [3];
   logic signed [OPW-1:0]  sel [3];
   vau_sat_type            sv [3];

   always_comb begin
      a[0] = sext_ew(req1_ff.ax);
      a[1] = sext_ew(req1_ff.ay);
      a[2] = sext_ew(req1_ff.az);
      b[0] = sext_ew(req1_ff.bx);
      b[1] = sext_ew(req1_ff.by);
      b[2] = sext_ew(req1_ff.bz);
      f    = sext_ew(req1_ff.factor);
      for (int i = 0; i < 3; i++) begin
         d[i]   = OPW'(a[i]) - OPW'(b[i]);
         sel[i] = '0;
      end
      case (req1_ff.mode)
         MODE_ADD: begin
            for (int i = 0; i < 3; i++) sel[i] = OPW'(a[i]) + OPW'(b[i]);
         end
         MODE_SUB: begin
            for (int i = 0; i < 3; i++) sel[i] = d[i];
         end
         MODE_NEG: begin
            for (int i = 0; i < 3; i++) sel[i] = -OPW'(a[i]);
         end
         default: begin
         end
      endcase
      for (int i = 0; i < 3; i++) sv[i] = sat_ew(SATW'(sel[i]));

      ctx2_in       = '0;
      ctx2_in.mode  = req1_ff.mode;
      for (int i = 0; i < 3; i++) begin
         ctx2_in.am[i]  = a[i][EW-1] ? -a[i] : a[i];
         ctx2_in.asn[i] = a[i][EW-1];
      end
      ctx2_in.fm    = f[EW-1] ? -f : f;
      ctx2_in.fsn   = f[EW-1];
      ctx2_in.fzero = (f == '0);
      if (req1_ff.mode inside {MODE_ADD, MODE_SUB, MODE_NEG}) begin
         ctx2_in.rsp.res_x = sv[0].val;
         ctx2_in.rsp.res_y = sv[1].val;
         ctx2_in.rsp.res_z = sv[2].val;
         ctx2_in.rsp.fault = (sv[0].ovf || sv[1].ovf || sv[2].ovf) ? FAULT_SAT : FAULT_NONE;
      end
      if (req1_ff.mode == MODE_EQUAL) begin
         ctx2_in.rsp.is_equal = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]);
      end

      for (int i = 0; i < 6; i++) begin
         opx2_in[i] = '0;
         opy2_in[i] = '0;
      end
      case (req1_ff.mode)
         MODE_SCALE: begin
            for (int i = 0; i < 3; i++) begin
               opx2_in[i] = OPW'(a[i]);
               opy2_in[i] = OPW'(f);
            end
         end
         MODE_DOT, MODE_PROJECT: begin
            for (int i = 0; i < 3; i++) begin
               opx2_in[i] = OPW'(a[i]);
               opy2_in[i] = OPW'(b[i]);
            end
         end
         MODE_CROSS: begin
            opx2_in[0] = OPW'(a[1]);  opy2_in[0] = OPW'(b[2]);
            opx2_in[1] = OPW'(a[2]);  opy2_in[1] = OPW'(b[1]);
            opx2_in[2] = OPW'(a[2]);  opy2_in[2] = OPW'(b[0]);
            opx2_in[3] = OPW'(a[0]);  opy2_in[3] = OPW'(b[2]);
            opx2_in[4] = OPW'(a[0]);  opy2_in[4] = OPW'(b[1]);
            opx2_in[5] = OPW'(a[1]);  opy2_in[5] = OPW'(b[0]);
         end
         MODE_NORM, MODE_LEN, MODE_LENSQ: begin
            for (int i = 0; i < 3; i++) begin
               opx2_in[i] = OPW'(a[i]);
               opy2_in[i] = OPW'(a[i]);
            end
         end
         MODE_DIST, MODE_DISTSQ: begin
            for (int i = 0; i < 3; i++) begin
               opx2_in[i] = d[i];
               opy2_in[i] = d[i];
            end
         end
         default: begin
         end
      endcase
   end

   // stage 3: products
   always_comb begin
      for (int i = 0; i < 6; i++) p3_in[i] = PW'(opx2_ff[i]) * PW'(opy2_ff[i]);
   end

   // stage 4: sums and differences
   always_comb begin
      for (int i = 0; i < 3; i++) c4_in[i] = SW'(p3_ff[i]);
      case (ctx3_ff.mode)
         MODE_DOT, MODE_PROJECT, MODE_NORM, MODE_LEN, MODE_LENSQ, MODE_DIST,
         MODE_DISTSQ: begin
            c4_in[0] = SW'(p3_ff[0]) + SW'(p3_ff[1]) + SW'(p3_ff[2]);
         end
         MODE_CROSS: begin
            c4_in[0] = SW'(p3_ff[0]) - SW'(p3_ff[1]);
            c4_in[1] = SW'(p3_ff[2]) - SW'(p3_ff[3]);
            c4_in[2] = SW'(p3_ff[4]) - SW'(p3_ff[5]);
         end
         default: begin
         end
      endcase
   end

   // stage 5: rescale and saturate
   logic signed [SW-1:0] sh5 [3];
   vau_sat_type          sr5 [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sh5[i] = c4_ff[i] >>> FRAC_BITS;
         sr5[i] = sat_ew(SATW'(sh5[i]));
      end
      ctx5_in = ctx4_ff;
      ps5_in  = $signed(sr5[0].val[EW-1:0]);
      case (ctx4_ff.mode)
         MODE_SCALE, MODE_CROSS: begin
            ctx5_in.rsp.res_x = sr5[0].val;
            ctx5_in.rsp.res_y = sr5[1].val;
            ctx5_in.rsp.res_z = sr5[2].val;
            ctx5_in.rsp.fault = (sr5[0].ovf || sr5[1].ovf || sr5[2].ovf) ? FAULT_SAT
                                                                         : FAULT_NONE;
         end
         MODE_DOT, MODE_LENSQ, MODE_DISTSQ: begin
            ctx5_in.rsp.res_scalar = sr5[0].val;
            ctx5_in.rsp.fault      = sr5[0].ovf ? FAULT_SAT : FAULT_NONE;
         end
         MODE_PROJECT: begin
            ctx5_in.rsp.fault = sr5[0].ovf ? FAULT_SAT : FAULT_NONE;
         end
         default: begin
         end
      endcase
   end

   // stage 6: projection products
   always_comb begin
      for (int i = 0; i < 3; i++) pp6_in[i] = PPW'(ps5_ff) * PPW'(b5_ff[i]);
   end

   // stage 7: projection rescale
   logic signed [PPW-1:0] sh7 [3];
   vau_sat_type           sr7 [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sh7[i] = pp6_ff[i] >>> FRAC_BITS;
         sr7[i] = sat_ew(SATW'(sh7[i]));
      end
      ctx7_in = ctx6_ff;
      if (ctx6_ff.mode == MODE_PROJECT) begin
         ctx7_in.rsp.res_x = sr7[0].val;
         ctx7_in.rsp.res_y = sr7[1].val;
         ctx7_in.rsp.res_z = sr7[2].val;
         if (sr7[0].ovf || sr7[1].ovf || sr7[2].ovf) ctx7_in.rsp.fault = FAULT_SAT;
      end
   end

   assign vld_in = {vld_ff[5:0], in_vld};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      req1_ff <= in_req;
      ctx2_ff <= ctx2_in;
      opx2_ff <= opx2_in;
      opy2_ff <= opy2_in;
      b2_ff   <= b;
      ctx3_ff <= ctx2_ff;
      p3_ff   <= p3_in;
      b3_ff   <= b2_ff;
      ctx4_ff <= ctx3_ff;
      c4_ff   <= c4_in;
      b4_ff   <= b3_ff;
      ctx5_ff <= ctx5_in;
      rad5_ff <= c4_ff[0][RADW-1:0];
      ps5_ff  <= ps5_in;
      b5_ff   <= b4_ff;
      ctx6_ff <= ctx5_ff;
      rad6_ff <= rad5_ff;
      pp6_ff  <= pp6_in;
      ctx7_ff <= ctx7_in;
      rad7_ff <= rad6_ff;
   end

   assign out_vld = vld_ff[6];
   assign out_rad = rad7_ff;
   assign out_ctx = ctx7_ff;

endmodule

FILE: src/vau_sqrt.sv
module vau_sqrt (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_vld,
   input  logic [vau_pkg::RADW-1:0]  in_rad,
   input  vau_pkg::vau_ctx_type      in_ctx,
   output logic                      out_vld,
   output logic [vau_pkg::RTW-1:0]   out_root,
   output vau_pkg::vau_ctx_type      out_ctx
);
   import vau_pkg::*;

   logic [RTW:0]      vld_ff, vld_in;
   logic [RW-1:0]     rem_ff  [RTW+1];
   logic [RW-1:0]     rem_in  [RTW+1];
   logic [RTW-1:0]    root_ff [RTW+1];
   logic [RTW-1:0]    root_in [RTW+1];
   logic [RADW-1:0]   rad_ff  [RTW+1];
   logic [RADW-1:0]   rad_in  [RTW+1];
   vau_ctx_type       ctx_ff  [RTW+1];
   vau_ctx_type       ctx_in  [RTW+1];

   logic [RW-1:0]     cur;
   logic [RW-1:0]     trial;

   // one result bit per stage, restoring
   always_comb begin
      vld_in[0]  = in_vld;
      rem_in[0]  = '0;
      root_in[0] = '0;
      rad_in[0]  = in_rad;
      ctx_in[0]  = in_ctx;
      for (int j = 0; j < RTW; j++) begin
         cur   = {rem_ff[j][RW-3:0], rad_ff[j][RADW-1 -: 2]};
         trial = RW'({root_ff[j], 2'b01});
         if (cur >= trial) begin
            rem_in[j+1]  = cur - trial;
            root_in[j+1] = {root_ff[j][RTW-2:0], 1'b1};
         end else begin
            rem_in[j+1]  = cur;
            root_in[j+1] = {root_ff[j][RTW-2:0], 1'b0};
         end
         rad_in[j+1] = {rad_ff[j][RADW-3:0], 2'b00};
         vld_in[j+1] = vld_ff[j];
         ctx_in[j+1] = ctx_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      root_ff <= root_in;
      rad_ff  <= rad_in;
      ctx_ff  <= ctx_in;
   end

   assign out_vld  = vld_ff[RTW];
   assign out_root = root_ff[RTW];
   assign out_ctx  = ctx_ff[RTW];

endmodule

FILE: src/vau_div.sv
module vau_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_vld,
   input  logic [vau_pkg::RTW-1:0]   in_root,
   input  vau_pkg::vau_ctx_type      in_ctx,
   output logic                      out_vld,
   output vau_pkg::vau_rsp_type      out_rsp
);
   import vau_pkg::*;

   logic [NUMW:0]     vld_ff, vld_in;
   vau_ctx_type       ctx_ff   [NUMW+1];
   vau_ctx_type       ctx_in   [NUMW+1];
   logic [EW-1:0]     dsor_ff  [NUMW+1];
   logic [EW-1:0]     dsor_in  [NUMW+1];
   logic [NUMW:0]     rzero_ff, rzero_in;
   logic [EW-1:0]     rem_ff   [NUMW+1][3];
   logic [EW-1:0]     rem_in   [NUMW+1][3];
   logic [NUMW-1:0]   nq_ff    [NUMW+1][3];
   logic [NUMW-1:0]   nq_in    [NUMW+1][3];

   logic              fin_vld_ff;
   vau_rsp_type       fin_ff, fin_in;

   vau_sat_type       rs;
   logic [EW:0]       r1;
   logic [EW:0]       dz;

   // stage 0: divisor pick, length result
   // stages 1..NUMW: one quotient bit per lane per stage
   always_comb begin
      rs          = sat_ew(SATW'(in_root));
      vld_in[0]   = in_vld;
      ctx_in[0]   = in_ctx;
      if (in_ctx.mode inside {MODE_LEN, MODE_DIST}) begin
         ctx_in[0].rsp.res_scalar = rs.val;
         ctx_in[0].rsp.fault      = rs.ovf ? FAULT_SAT : FAULT_NONE;
      end
      dsor_in[0]  = (in_ctx.mode == MODE_NORM) ? in_root[EW-1:0] : in_ctx.fm;
      rzero_in[0] = (in_root == '0);
      for (int i = 0; i < 3; i++) begin
         rem_in[0][i] = '0;
         nq_in[0][i]  = {in_ctx.am[i], {FRAC_BITS{1'b0}}};
      end
      for (int j = 0; j < NUMW; j++) begin
         vld_in[j+1]   = vld_ff[j];
         ctx_in[j+1]   = ctx_ff[j];
         dsor_in[j+1]  = dsor_ff[j];
         rzero_in[j+1] = rzero_ff[j];
         dz            = {1'b0, dsor_ff[j]};
         for (int i = 0; i < 3; i++) begin
            r1 = {rem_ff[j][i], nq_ff[j][i][NUMW-1]};
            if (r1 >= dz) begin
               rem_in[j+1][i] = EW'(r1 - dz);
               nq_in[j+1][i]  = {nq_ff[j][i][NUMW-2:0], 1'b1};
            end else begin
               rem_in[j+1][i] = r1[EW-1:0];
               nq_in[j+1][i]  = {nq_ff[j][i][NUMW-2:0], 1'b0};
            end
         end
      end
   end

   // final sign, saturation and mode select
   vau_ctx_type             lc;
   logic signed [SATW-1:0]  qs [3];
   vau_sat_type             qr [3];
   logic                    qneg;

   always_comb begin
      lc = ctx_ff[NUMW];
      for (int i = 0; i < 3; i++) begin
         qneg  = (lc.mode == MODE_DIV) ? (lc.asn[i] ^ lc.fsn) : lc.asn[i];
         qs[i] = qneg ? -SATW'(nq_ff[NUMW][i]) : SATW'(nq_ff[NUMW][i]);
         qr[i] = sat_ew(qs[i]);
      end
      fin_in = lc.rsp;
      case (lc.mode)
         MODE_DIV: begin
            if (lc.fzero) begin
               fin_in.fault = FAULT_DIV0;
            end else begin
               fin_in.res_x = qr[0].val;
               fin_in.res_y = qr[1].val;
               fin_in.res_z = qr[2].val;
               fin_in.fault = (qr[0].ovf || qr[1].ovf || qr[2].ovf) ? FAULT_SAT : FAULT_NONE;
            end
         end
         MODE_NORM: begin
            // zero vector comes back as is, which is all zeros
            if (!rzero_ff[NUMW]) begin
               fin_in.res_x = qr[0].val;
               fin_in.res_y = qr[1].val;
               fin_in.res_z = qr[2].val;
               fin_in.fault = (qr[0].ovf || qr[1].ovf || qr[2].ovf) ? FAULT_SAT : FAULT_NONE;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         fin_vld_ff <= 1'b0;
      end else begin
         vld_ff     <= vld_in;
         fin_vld_ff <= vld_ff[NUMW];
      end
   end

   always_ff @(posedge clock) begin
      ctx_ff   <= ctx_in;
      dsor_ff  <= dsor_in;
      rzero_ff <= rzero_in;
      rem_ff   <= rem_in;
      nq_ff    <= nq_in;
      fin_ff   <= fin_in;
   end

   assign out_vld = fin_vld_ff;
   assign out_rsp = fin_ff;

endmodule

FILE: src/vector3_arithmetic_unit.sv
// Pipeline: 7 product stages, WORD+2 root stages, WORD+FRAC+2 divide stages; rsp_valid
//   marks the result of a request once it has passed through all of them.
// Throughput: one request beat per cycle; busy is always low, results are never held.
// Reset: synchronous, active high; clears only the stage valid bits, so no strobe
//   follows reset until new requests arrive.
module vector3_arithmetic_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  vau_pkg::vau_req_type  req_data,
   output logic                  rsp_valid,
   output vau_pkg::vau_rsp_type  rsp_data
);
   import vau_pkg::*;

   logic              prod_vld;
   logic [RADW-1:0]   prod_rad;
   vau_ctx_type       prod_ctx;
   logic              sq_vld;
   logic [RTW-1:0]    sq_root;
   vau_ctx_type       sq_ctx;

   assign busy = 1'b0;

   vau_prod u_prod (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (start && !busy),
      .in_req  (req_data),
      .out_vld (prod_vld),
      .out_rad (prod_rad),
      .out_ctx (prod_ctx)
   );

   vau_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (prod_vld),
      .in_rad   (prod_rad),
      .in_ctx   (prod_ctx),
      .out_vld  (sq_vld),
      .out_root (sq_root),
      .out_ctx  (sq_ctx)
   );

   vau_div u_div (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (sq_vld),
      .in_root (sq_root),
      .in_ctx  (sq_ctx),
      .out_vld (rsp_valid),
      .out_rsp (rsp_data)
   );

endmodule

FILE: tb/tb.sv
module tb;
   import vau_pkg::*;

   localparam int LIMIT = 400000;
   localparam int W     = 130;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   vau_req_type  req_data = '0;
   logic         rsp_valid;
   vau_rsp_type  rsp_data;

   vau_rsp_type  expected_rsps[$];
   int           errors    = 0;
   int           cycles    = 0;
   int           sent      = 0;
   int           checked   = 0;
   bit           calm      = 1'b0;
   int           mode_hits[16];

   vector3_arithmetic_unit dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor
   function automatic logic signed [31:0] clamp(input logic signed [W-1:0] v,
                                                inout logic [1:0] flt);
      if (v > $signed(W'(32'sh7fffffff))) begin
         flt = FAULT_SAT;
         return 32'sh7fffffff;
      end
      if (v < -$signed(W'(64'h80000000))) begin
         flt = FAULT_SAT;
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic logic [W-1:0] int_sqrt(input logic [W-1:0] n);
      logic [W-1:0] r;
      logic [W-1:0] t;
      r = '0;
      for (int i = 33; i >= 0; i--) begin
         t = r | (W'(1) << i);
         if (t * t <= n) r = t;
      end
      return r;
   endfunction

   function automatic logic signed [W-1:0] sum_sq(input logic signed [W-1:0] x0,
                                                  input logic signed [W-1:0] x1,
                                                  input logic signed [W-1:0] x2);
      return x0 * x0 + x1 * x1 + x2 * x2;
   endfunction

   function automatic vau_rsp_type vector_result(input vau_req_type q);
      logic signed [W-1:0] a[3];
      logic signed [W-1:0] b[3];
      logic signed [W-1:0] d[3];
      logic signed [W-1:0] f;
      logic signed [W-1:0] acc;
      logic signed [W-1:0] mag_len;
      logic signed [31:0]  v[3];
      logic signed [31:0]  sc;
      logic [1:0]          flt;
      logic                eq;
      vau_rsp_type         r;
      a[0] = $signed(q.ax); a[1] = $signed(q.ay); a[2] = $signed(q.az);
      b[0] = $signed(q.bx); b[1] = $signed(q.by); b[2] = $signed(q.bz);
      f = $signed(q.factor);
      for (int i = 0; i < 3; i++) begin
         d[i] = a[i] - b[i];
         v[i] = '0;
      end
      sc  = '0;
      flt = FAULT_NONE;
      eq  = 1'b0;
      case (q.mode)
         MODE_ADD:   for (int i = 0; i < 3; i++) v[i] = clamp(a[i] + b[i], flt);
         MODE_SUB:   for (int i = 0; i < 3; i++) v[i] = clamp(d[i], flt);
         MODE_NEG:   for (int i = 0; i < 3; i++) v[i] = clamp(-a[i], flt);
         MODE_SCALE: for (int i = 0; i < 3; i++) v[i] = clamp((a[i] * f) >>> FRAC_BITS, flt);
         MODE_DIV: begin
            if (f == 0) flt = FAULT_DIV0;
            else for (int i = 0; i < 3; i++) v[i] = clamp((a[i] <<< FRAC_BITS) / f, flt);
         end
         MODE_DOT, MODE_PROJECT: begin
            acc = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
            sc  = clamp(acc >>> FRAC_BITS, flt);
            if (q.mode == MODE_PROJECT) begin
               acc = $signed(sc);
               for (int i = 0; i < 3; i++) v[i] = clamp((acc * b[i]) >>> FRAC_BITS, flt);
               sc = '0;
            end
         end
         MODE_CROSS: begin
            v[0] = clamp((a[1] * b[2] - a[2] * b[1]) >>> FRAC_BITS, flt);
            v[1] = clamp((a[2] * b[0] - a[0] * b[2]) >>> FRAC_BITS, flt);
            v[2] = clamp((a[0] * b[1] - a[1] * b[0]) >>> FRAC_BITS, flt);
         end
         MODE_NORM: begin
            acc = sum_sq(a[0], a[1], a[2]);
            if (acc == 0) begin
               for (int i = 0; i < 3; i++) v[i] = a[i][31:0];
            end else begin
               mag_len = $signed(int_sqrt(acc));
               for (int i = 0; i < 3; i++) v[i] = clamp((a[i] <<< FRAC_BITS) / mag_len, flt);
            end
         end
         MODE_LEN:    sc = clamp($signed(int_sqrt(sum_sq(a[0], a[1], a[2]))), flt);
         MODE_LENSQ:  sc = clamp(sum_sq(a[0], a[1], a[2]) >>> FRAC_BITS, flt);
         MODE_DIST:   sc = clamp($signed(int_sqrt(sum_sq(d[0], d[1], d[2]))), flt);
         MODE_DISTSQ: sc = clamp(sum_sq(d[0], d[1], d[2]) >>> FRAC_BITS, flt);
         MODE_EQUAL:  eq = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]);
         default: ;
      endcase
      r.res_x      = v[0];
      r.res_y      = v[1];
      r.res_z      = v[2];
      r.res_scalar = sc;
      r.is_equal   = eq;
      r.fault      = flt;
      return r;
   endfunction

   // ---------------------------------------------------------------- driving
   function automatic vau_req_type make_req(input logic [3:0] m,
                                            input logic [31:0] ax, input logic [31:0] ay,
                                            input logic [31:0] az, input logic [31:0] bx,
                                            input logic [31:0] by, input logic [31:0] bz,
                                            input logic [31:0] fac);
      vau_req_type q;
      q.mode = m;
      q.ax = ax; q.ay = ay; q.az = az;
      q.bx = bx; q.by = by; q.bz = bz;
      q.factor = fac;
      return q;
   endfunction

   task automatic send_beat(input vau_req_type q);
      @(negedge clock);
      start    = 1'b1;
      req_data = q;
      do @(posedge clock); while (busy);
      expected_rsps.push_back(vector_result(q));
      mode_hits[q.mode]++;
      sent++;
      if (!calm && $urandom_range(99) < 6) begin
         @(negedge clock);
         start = 1'b0;
         repeat ($urandom_range(0, 5)) @(negedge clock);
      end
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at cycle %0d: %s got %h expected %h", cycles, field, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      vau_rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $display("unexpected result at cycle %0d", cycles);
            errors++;
         end else begin
            want = expected_rsps.pop_front();
            checked++;
            if (rsp_data.res_x !== want.res_x)
               report_mismatch("res_x", rsp_data.res_x, want.res_x);
            if (rsp_data.res_y !== want.res_y)
               report_mismatch("res_y", rsp_data.res_y, want.res_y);
            if (rsp_data.res_z !== want.res_z)
               report_mismatch("res_z", rsp_data.res_z, want.res_z);
            if (rsp_data.res_scalar !== want.res_scalar)
               report_mismatch("res_scalar", rsp_data.res_scalar, want.res_scalar);
            if (rsp_data.is_equal !== want.is_equal)
               report_mismatch("is_equal", 32'(rsp_data.is_equal), 32'(want.is_equal));
            if (rsp_data.fault !== want.fault)
               report_mismatch("fault", 32'(rsp_data.fault), 32'(want.fault));
         end
      end
   end

   // ---------------------------------------------------------------- stimulus
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'($signed(20'($urandom())));
         2: return 32'($signed(24'($urandom())));
         3: begin
            case ($urandom_range(0, 5))
               0: return 32'h7fffffff;
               1: return 32'h80000000;
               2: return 32'h0;
               3: return 32'hffffffff;
               4: return 32'h00010000;
               default: return 32'hffff0000;
            endcase
         end
         4: return 32'($signed(12'($urandom())));
         default: return 32'($signed(28'($urandom())));
      endcase
   endfunction

   task automatic test_linear_ops();
      send_beat(make_req(MODE_ADD, 32'h7fffffff, 32'h80000000, 1, 1, 32'hffffffff, 5, 0));
      send_beat(make_req(MODE_SUB, 32'h80000000, 32'h7fffffff, 3, 1, 32'hffffffff, 3, 0));
      send_beat(make_req(MODE_NEG, 32'h80000000, 32'h7fffffff, 0, 0, 0, 0, 0));
      send_beat(make_req(MODE_SCALE, 32'h00020000, 32'hfffe0000, 32'h7fffffff, 0, 0, 0,
                         32'h00018000));
      send_beat(make_req(MODE_SCALE, 32'h80000000, 32'h7fffffff, 32'h1, 0, 0, 0, 32'h80000000));
      send_beat(make_req(MODE_EQUAL, 32'h10, 32'h20, 32'h30, 32'h10, 32'h20, 32'h30, 0));
      send_beat(make_req(MODE_EQUAL, 32'h10, 32'h20, 32'h30, 32'h10, 32'h20, 32'h31, 0));
   endtask

   task automatic test_products();
      send_beat(make_req(MODE_DOT, 32'h00010000, 32'h00020000, 32'h00030000,
                         32'h00040000, 32'hfffb0000, 32'h00060000, 0));
      send_beat(make_req(MODE_DOT, 32'h80000000, 32'h80000000, 32'h80000000,
                         32'h80000000, 32'h80000000, 32'h80000000, 0));
      send_beat(make_req(MODE_CROSS, 32'h00010000, 0, 0, 0, 32'h00010000, 0, 0));
      send_beat(make_req(MODE_CROSS, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                         32'h80000000, 32'h7fffffff, 32'h80000000, 0));
      send_beat(make_req(MODE_PROJECT, 32'h00030000, 32'h00040000, 0,
                         32'h00010000, 0, 0, 0));
      send_beat(make_req(MODE_PROJECT, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                         32'h7fffffff, 32'h80000000, 32'h7fffffff, 0));
   endtask

   task automatic test_roots();
      send_beat(make_req(MODE_LEN, 32'h00030000, 32'h00040000, 0, 0, 0, 0, 0));
      send_beat(make_req(MODE_LEN, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0));
      send_beat(make_req(MODE_LENSQ, 32'h80000000, 32'h7fffffff, 32'h1, 0, 0, 0, 0));
      send_beat(make_req(MODE_DIST, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                         32'h80000000, 32'h80000000, 32'h80000000, 0));
      send_beat(make_req(MODE_DISTSQ, 32'h00050000, 0, 0, 32'h00020000, 0, 0, 0));
      send_beat(make_req(MODE_NORM, 32'h00030000, 32'h00040000, 0, 0, 0, 0, 0));
      send_beat(make_req(MODE_NORM, 32'h1, 0, 0, 0, 0, 0, 0));
   endtask

   task automatic test_special_cases();
      // zero vector normalizes to itself, zero divisor, unused codes
      send_beat(make_req(MODE_NORM, 0, 0, 0, 32'h5, 32'h6, 32'h7, 32'h8));
      send_beat(make_req(MODE_DIV, 32'h00010000, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0));
      send_beat(make_req(MODE_DIV, 32'h7fffffff, 32'h80000000, 32'hfffe0000, 0, 0, 0, 32'h1));
      send_beat(make_req(MODE_DIV, 32'h00030000, 32'hfffd0000, 32'h1, 0, 0, 0, 32'hfffe0000));
      send_beat(make_req(4'd14, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                         32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff));
      send_beat(make_req(4'd15, 32'h1, 32'h2, 32'h3, 32'h4, 32'h5, 32'h6, 32'h7));
   endtask

   task automatic test_random(input int count);
      vau_req_type q;
      for (int n = 0; n < count; n++) begin
         calm = (n >= count / 3) && (n < count / 2);
         q.mode = ($urandom_range(99) < 3) ? 4'($urandom_range(14, 15))
                                           : 4'($urandom_range(0, 13));
         q.ax = pick_value(); q.ay = pick_value(); q.az = pick_value();
         q.bx = pick_value(); q.by = pick_value(); q.bz = pick_value();
         q.factor = pick_value();
         if (q.mode == MODE_EQUAL && $urandom_range(1)) begin
            q.bx = q.ax; q.by = q.ay;
            if ($urandom_range(1)) q.bz = q.az;
         end
         if (q.mode == MODE_NORM && $urandom_range(99) < 5) begin
            q.ax = '0; q.ay = '0; q.az = '0;
         end
         send_beat(q);
      end
      calm = 1'b0;
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset = 1'b0;
      test_linear_ops();
      test_products();
      test_roots();
      test_special_cases();
      test_random(1300);
      @(negedge clock);
      start = 1'b0;
      wait (expected_rsps.size() == 0);
      repeat (120) @(posedge clock);
      $display("sent %0d requests covering all 16 mode codes, checked %0d results", sent, checked);
      $display("divide, root and saturation paths exercised with extreme and random operands");
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
